/* design/rmus_pkg.sv */
// rmus_pkg: shared constants for the rectangle minimum update store
// fixed field widths, item field positions, register indexes and codes
// no dependencies
package rmus_pkg;

  // configuration port
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 1'b1;
  localparam logic [CFG_W-1:0]     COUNT_RESET     = 8'd128;

  // input item fields
  localparam int IDX_W         = 7;
  localparam int MASK_W        = 4;
  localparam int ROW_FIRST_LSB = 0;
  localparam int ROW_LAST_LSB  = ROW_FIRST_LSB + IDX_W;
  localparam int COL_FIRST_LSB = ROW_LAST_LSB + IDX_W;
  localparam int COL_LAST_LSB  = COL_FIRST_LSB + IDX_W;
  localparam int MASK_LSB      = COL_LAST_LSB + IDX_W;
  localparam int ENERGY_LSB    = MASK_LSB + MASK_W;

  // to-end mask bits
  localparam int TE_ROW_FIRST = 0;
  localparam int TE_ROW_LAST  = 1;
  localparam int TE_COL_FIRST = 2;
  localparam int TE_COL_LAST  = 3;

  // item kind
  localparam logic ACT_UPDATE = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  // result status
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

endpackage

/* design/rectangle_min_update_store_unit.sv */
// rectangle_min_update_store_unit: two-dimensional store of minimum energies
// with rectangle minimum updates and single-cell reads
// depends on rmus_pkg
//
// sequence: an update reads its rectangle cell by cell, one cell per cycle, then
//   drains the last write-back and loads the output register once it is free; a read
//   walks its single cell alike, a rejected item goes straight to the output register
// one item at a time: input is ready only once the previous result has been loaded
// reset: synchronous, active high; it then sweeps the memory writing infinity, one cell a
//   cycle over MAX_ROWS * 2**ceil(log2(MAX_COLS)) cells (16384 by default), no item taken
module rectangle_min_update_store_unit #(
  parameter int MAX_ROWS     = 128,
  parameter int MAX_COLS     = 128,
  parameter int ENERGY_WIDTH = 16,
  localparam int IN_W  = ((rmus_pkg::ENERGY_LSB + ENERGY_WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((ENERGY_WIDTH + 2 + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration writes
  input  logic                           cfg_we,
  input  logic [rmus_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rmus_pkg::CFG_W-1:0]     cfg_wdata,
  // input items
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // row_first, row_last, col_first, col_last, to_end_mask, energy, zero pad
  input  logic [IN_W-1:0]                s_axis_tdata,
  // action
  input  logic                           s_axis_tuser,
  // result items
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // status, cell_energy, cell_is_infinite, zero pad
  output logic [OUT_W-1:0]               m_axis_tdata
);

  // address split: row in the upper bits, column in the lower bits
  localparam int RB    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CB    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AW    = RB + CB;
  localparam int DEPTH = MAX_ROWS * (2 ** CB);
  // width for index against count compares, wide enough for the register and the count
  localparam int RCW   = ($clog2(MAX_ROWS + 1) > rmus_pkg::CFG_W) ?
                         $clog2(MAX_ROWS + 1) : rmus_pkg::CFG_W;
  localparam int CCW   = ($clog2(MAX_COLS + 1) > rmus_pkg::CFG_W) ?
                         $clog2(MAX_COLS + 1) : rmus_pkg::CFG_W;
  localparam logic signed [ENERGY_WIDTH-1:0] E_INF = {1'b0, {(ENERGY_WIDTH-1){1'b1}}};

  // sequencer states
  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_WALK   = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_RESULT = 3'd4;

  logic [2:0] state;

  // configuration registers
  logic [rmus_pkg::CFG_W-1:0] rows_in_use;
  logic [rmus_pkg::CFG_W-1:0] cols_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= rmus_pkg::COUNT_RESET;
      cols_in_use <= rmus_pkg::COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rmus_pkg::REG_ROWS_IN_USE: rows_in_use <= cfg_wdata;
        rmus_pkg::REG_COLS_IN_USE: cols_in_use <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // effective counts: zero acts as one, anything above the maximum as the maximum
  logic [RCW-1:0] rows_ext, n_rows;
  logic [CCW-1:0] cols_ext, n_cols;

  always_comb begin
    rows_ext = RCW'(rows_in_use);
    cols_ext = CCW'(cols_in_use);
    if (rows_ext == '0)                 n_rows = RCW'(1);
    else if (rows_ext > RCW'(MAX_ROWS)) n_rows = RCW'(MAX_ROWS);
    else                                n_rows = rows_ext;
    if (cols_ext == '0)                 n_cols = CCW'(1);
    else if (cols_ext > CCW'(MAX_COLS)) n_cols = CCW'(MAX_COLS);
    else                                n_cols = cols_ext;
  end

  // input item fields
  logic                               in_action;
  logic [rmus_pkg::MASK_W-1:0]        in_mask;
  logic signed [ENERGY_WIDTH-1:0]     in_energy;
  logic [RCW-1:0]                     r0, r1;
  logic [CCW-1:0]                     c0, c1;
  logic                               read_bad, upd_bad, in_bad;

  always_comb begin
    in_action = s_axis_tuser;
    in_mask   = s_axis_tdata[rmus_pkg::MASK_LSB +: rmus_pkg::MASK_W];
    in_energy = s_axis_tdata[rmus_pkg::ENERGY_LSB +: ENERGY_WIDTH];

    // corners marked to-end take the last row or column in use
    r0 = in_mask[rmus_pkg::TE_ROW_FIRST] ? n_rows - RCW'(1) :
         RCW'(s_axis_tdata[rmus_pkg::ROW_FIRST_LSB +: rmus_pkg::IDX_W]);
    r1 = in_mask[rmus_pkg::TE_ROW_LAST]  ? n_rows - RCW'(1) :
         RCW'(s_axis_tdata[rmus_pkg::ROW_LAST_LSB +: rmus_pkg::IDX_W]);
    c0 = in_mask[rmus_pkg::TE_COL_FIRST] ? n_cols - CCW'(1) :
         CCW'(s_axis_tdata[rmus_pkg::COL_FIRST_LSB +: rmus_pkg::IDX_W]);
    c1 = in_mask[rmus_pkg::TE_COL_LAST]  ? n_cols - CCW'(1) :
         CCW'(s_axis_tdata[rmus_pkg::COL_LAST_LSB +: rmus_pkg::IDX_W]);

    // a read only looks at the first corner
    read_bad = (r0 >= n_rows) || (c0 >= n_cols);
    upd_bad  = read_bad || (r1 >= n_rows) || (c1 >= n_cols) || (r0 > r1) || (c0 > c1);
    in_bad   = (in_action == rmus_pkg::ACT_READ) ? read_bad : upd_bad;
  end

  assign s_axis_tready = (state == ST_IDLE);

  logic accept;
  assign accept = s_axis_tvalid && s_axis_tready;

  // item being worked on
  logic                           op_read;
  logic                           op_bad;
  logic signed [ENERGY_WIDTH-1:0] e_q;
  logic [RB-1:0]                  row_first, row_last, cur_row;
  logic [CB-1:0]                  col_first, col_last, cur_col;
  logic [AW-1:0]                  clr_addr;

  // cell memory, registered read
  logic signed [ENERGY_WIDTH-1:0] mem [DEPTH];
  logic signed [ENERGY_WIDTH-1:0] mem_q;
  logic                           mem_re, mem_we;
  logic [AW-1:0]                  mem_raddr, mem_waddr;
  logic signed [ENERGY_WIDTH-1:0] mem_wdata;

  // write-back stage: the cell read in the previous cycle
  logic          pend;
  logic [AW-1:0] pend_addr;

  always_comb begin
    mem_re    = (state == ST_WALK);
    mem_raddr = {cur_row, cur_col};
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = E_INF;
    end else begin
      // lower the cell only where the new energy is below it
      mem_we    = pend && (e_q < mem_q);
      mem_waddr = pend_addr;
      mem_wdata = e_q;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= mem[mem_raddr];
    end
  end

  // output register
  logic                           out_status;
  logic signed [ENERGY_WIDTH-1:0] out_energy;
  logic                           out_inf;
  logic                           out_load;

  assign out_load = (state == ST_RESULT) && (!m_axis_tvalid || m_axis_tready);

  // sequencer: clearing sweep, then one item at a time, a valid one walking its cells row by row
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      pend     <= 1'b0;
    end else begin
      // each cell read by an update is written back in the next cycle if the new energy is lower
      pend <= (state == ST_WALK) && !op_read;
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state <= in_bad ? ST_RESULT : ST_WALK;
          end
        end
        ST_WALK: begin
          if ((cur_col == col_last) && (cur_row == row_last)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_RESULT;
        end
        ST_RESULT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_CLEAR;
      endcase
    end
  end

  // item registers and walk counters
  always_ff @(posedge clk) begin
    pend_addr <= {cur_row, cur_col};
    if (accept) begin
      op_read   <= (in_action == rmus_pkg::ACT_READ);
      op_bad    <= in_bad;
      e_q       <= in_energy;
      row_first <= r0[RB-1:0];
      col_first <= c0[CB-1:0];
      cur_row   <= r0[RB-1:0];
      cur_col   <= c0[CB-1:0];
      // a read walks the single cell at its first corner
      row_last  <= (in_action == rmus_pkg::ACT_READ) ? r0[RB-1:0] : r1[RB-1:0];
      col_last  <= (in_action == rmus_pkg::ACT_READ) ? c0[CB-1:0] : c1[CB-1:0];
    end else if (state == ST_WALK) begin
      if (cur_col == col_last) begin
        cur_col <= col_first;
        cur_row <= cur_row + RB'(1);
      end else begin
        cur_col <= cur_col + CB'(1);
      end
    end
  end

  // result register, held until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= op_bad ? rmus_pkg::STATUS_BAD : rmus_pkg::STATUS_OK;
      out_energy <= (op_read && !op_bad) ? mem_q : '0;
      out_inf    <= op_read && !op_bad && (mem_q == E_INF);
    end
  end

  always_comb begin
    m_axis_tdata                    = '0;
    m_axis_tdata[0]                 = out_status;
    m_axis_tdata[ENERGY_WIDTH:1]    = out_energy;
    m_axis_tdata[ENERGY_WIDTH+1]    = out_inf;
  end

endmodule

/* design/rmus_checker.sv */
// rmus_checker: port-level assertions for the rectangle minimum update store
// depends on rmus_pkg, bound to rectangle_min_update_store_unit
module rmus_checker #(
  parameter int ENERGY_WIDTH = 16,
  parameter int OUT_W        = 24
) (
  input logic             clk,
  input logic             rst,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  localparam logic [ENERGY_WIDTH-1:0] E_INF = {1'b0, {(ENERGY_WIDTH-1){1'b1}}};

  // result stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped before it was taken");

  // stalled result keeps its bits
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("stalled result changed");

  // one item at a time: no second item straight after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item taken while another is in progress");

  // after reset nothing is offered and the clearing sweep blocks input
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && !s_axis_tready)
    else $error("activity straight after reset");

  // an infinite flag only comes with a good read of the infinity value
  a_inf_value: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[ENERGY_WIDTH+1] |->
      (m_axis_tdata[ENERGY_WIDTH:1] == E_INF) && (m_axis_tdata[0] == rmus_pkg::STATUS_OK))
    else $error("infinite flag with a finite value or bad status");

endmodule

bind rectangle_min_update_store_unit rmus_checker #(
  .ENERGY_WIDTH(ENERGY_WIDTH),
  .OUT_W       (OUT_W)
) u_rmus_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
